### design/rcpd_pkg.sv
// ---------------------------------------------------------------------------
// rcpd_pkg : shared constants for the RC pulse decode and drive block
// Register indexes, reset values, field widths and arithmetic constants.
// ---------------------------------------------------------------------------
package rcpd_pkg;

   // default width of the tick timers
   localparam int TIME_BITS_DEFAULT = 32;

   // configuration register widths
   localparam int TIMEOUT_BITS   = 20;
   localparam int CENTER_BITS    = 12;
   localparam int THRESHOLD_BITS = 7;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 20;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SIGNAL_TIMEOUT = 2'd0,
      CSR_CENTER_PULSE   = 2'd1,
      CSR_TURN_THRESHOLD = 2'd2,
      CSR_UNUSED         = 2'd3
   } csr_index_type;

   // register reset values
   localparam logic [TIMEOUT_BITS-1:0]   TIMEOUT_RESET   = 20'd30000;
   localparam logic [CENTER_BITS-1:0]    CENTER_RESET    = 12'd1500;
   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 7'd20;

   // pulse width held per channel after reset
   localparam int DEFAULT_PULSE = 1500;

   // command arithmetic
   localparam int CMD_BITS    = 7;                  // magnitude 0..100
   localparam logic [CMD_BITS-1:0] CMD_LIMIT = 7'd100;
   localparam int MAG_BITS    = 9;                  // unsaturated magnitudes 0..504
   localparam logic [MAG_BITS-1:0] MAG_LIMIT = 9'd504;   // 5*100 + 4
   localparam logic [7:0]  DIV5_RECIP = 8'd205;     // x/5 = (x*205)>>10 for x < 1024
   localparam int DIV5_SHIFT  = 10;
   localparam logic [16:0] DUTY_RECIP = 17'd83559;  // q*255/100 = (q*83559)>>15
   localparam int DUTY_SHIFT  = 15;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;

   // stream widths
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 48;

   // input pin positions in req_tdata
   localparam int PIN_THROTTLE = 0;
   localparam int PIN_STEERING = 1;
   localparam int PIN_LIGHT    = 2;
   localparam int PIN_HORN     = 3;

endpackage

### design/rcpd_front.sv
// ---------------------------------------------------------------------------
// rcpd_front : pin edge detection and pulse width timing
// Takes one tick beat a cycle while the queue accepts, tracks rise and fall
// times per RC channel, applies the signal timeout and pushes the chosen widths to the queue.
// ---------------------------------------------------------------------------
module rcpd_front #(
   parameter int TIME_BITS = rcpd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [rcpd_pkg::TIMEOUT_BITS-1:0]    signal_timeout,
   input  logic [rcpd_pkg::CENTER_BITS-1:0]     center_pulse,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [3:0]                           in_pins,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output logic [2*TIME_BITS+1:0]               push_data    // w0, w1, light, horn
);

   localparam int CMP_BITS = (TIME_BITS > rcpd_pkg::TIMEOUT_BITS) ?
                             TIME_BITS : rcpd_pkg::TIMEOUT_BITS;

   logic                 accept;
   logic [TIME_BITS-1:0] tick_ff, tick_in;
   logic [1:0]           prev_ff, prev_in;
   logic [TIME_BITS-1:0] rise_ff  [2];
   logic [TIME_BITS-1:0] rise_in  [2];
   logic [TIME_BITS-1:0] width_ff [2];
   logic [TIME_BITS-1:0] width_in [2];
   logic [TIME_BITS-1:0] last_ff  [2];
   logic [TIME_BITS-1:0] last_in  [2];
   logic [TIME_BITS-1:0] elapsed  [2];
   logic [TIME_BITS-1:0] chosen   [2];
   logic [1:0]           levels;

   assign accept     = in_valid && push_ready;
   assign in_ready   = push_ready;
   assign push_valid = in_valid;
   assign levels     = {in_pins[rcpd_pkg::PIN_STEERING], in_pins[rcpd_pkg::PIN_THROTTLE]};

   // edge handling and timeout fallback per channel
   always_comb begin
      tick_in = tick_ff + TIME_BITS'(1);
      prev_in = levels;
      for (int ch = 0; ch < 2; ch++) begin
         rise_in[ch]  = rise_ff[ch];
         width_in[ch] = width_ff[ch];
         last_in[ch]  = last_ff[ch];
         if (levels[ch] && !prev_ff[ch]) begin
            rise_in[ch] = tick_ff;
            last_in[ch] = tick_ff;
         end else if (!levels[ch] && prev_ff[ch]) begin
            width_in[ch] = tick_ff - rise_ff[ch];
            last_in[ch]  = tick_ff;
         end
         elapsed[ch] = tick_ff - last_in[ch];
         if (CMP_BITS'(elapsed[ch]) > CMP_BITS'(signal_timeout)) begin
            chosen[ch] = TIME_BITS'(center_pulse);
         end else begin
            chosen[ch] = width_in[ch];
         end
      end
   end

   assign push_data = {in_pins[rcpd_pkg::PIN_HORN], in_pins[rcpd_pkg::PIN_LIGHT],
                       chosen[1], chosen[0]};

   // timing state
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         prev_ff <= '0;
         for (int ch = 0; ch < 2; ch++) begin
            rise_ff[ch]  <= '0;
            width_ff[ch] <= TIME_BITS'(rcpd_pkg::DEFAULT_PULSE);
            last_ff[ch]  <= '0;
         end
      end else if (accept) begin
         tick_ff <= tick_in;
         prev_ff <= prev_in;
         for (int ch = 0; ch < 2; ch++) begin
            rise_ff[ch]  <= rise_in[ch];
            width_ff[ch] <= width_in[ch];
            last_ff[ch]  <= last_in[ch];
         end
      end
   end

endmodule

### design/rcpd_queue.sv
// ---------------------------------------------------------------------------
// rcpd_queue : short queue between front and back
// Small register queue; push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
module rcpd_queue #(
   parameter int DATA_BITS = 2 * rcpd_pkg::TIME_BITS_DEFAULT + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output logic [DATA_BITS-1:0] pop_data
);

   localparam int PB = rcpd_pkg::QUEUE_PTR_BITS;

   logic [DATA_BITS-1:0] mem [rcpd_pkg::QUEUE_DEPTH];
   logic [PB-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PB:0]          count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != (PB+1)'(rcpd_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = mem[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PB'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PB'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PB+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PB+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/rcpd_back.sv
// ---------------------------------------------------------------------------
// rcpd_back : command mapping and drive output pipeline
// Four stalling stages: offset from centre, magnitude and saturation,
// divide by five, then duty, direction and lamp logic into the result beat.
// ---------------------------------------------------------------------------
module rcpd_back #(
   parameter int TIME_BITS = rcpd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [rcpd_pkg::CENTER_BITS-1:0]      center_pulse,
   input  logic [rcpd_pkg::THRESHOLD_BITS-1:0]   turn_threshold,
   input  logic                                  pop_valid,
   output logic                                  pop_ready,
   input  logic [2*TIME_BITS+1:0]                pop_data,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [rcpd_pkg::RSP_DATA_BITS-1:0]    out_data
);

   localparam int MB = rcpd_pkg::MAG_BITS;
   localparam int CB = rcpd_pkg::CMD_BITS;

   logic                 en;
   logic [TIME_BITS-1:0] center_ext;

   // stage 1: signed offset both ways
   logic                 s1_valid_ff;
   logic [TIME_BITS-1:0] s1_pos_ff [2];
   logic [TIME_BITS-1:0] s1_neg_ff [2];
   logic [1:0]           s1_sw_ff;        // light, horn
   // stage 2: sign, clipped magnitude, saturation
   logic                 s2_valid_ff;
   logic [1:0]           s2_sign_ff;
   logic [1:0]           s2_sat_ff;
   logic [MB-1:0]        s2_mag_ff [2];
   logic [1:0]           s2_sw_ff;
   logic [TIME_BITS-1:0] mag_in [2];
   logic [1:0]           sat_in;
   // stage 3: command magnitude
   logic                 s3_valid_ff;
   logic [1:0]           s3_sign_ff;
   logic [CB-1:0]        s3_q_ff [2];
   logic [1:0]           s3_sw_ff;
   logic [16:0]          div_prod [2];
   logic [CB-1:0]        q_in [2];
   // result stage
   logic                 out_valid_ff;
   logic [rcpd_pkg::RSP_DATA_BITS-1:0] out_data_ff, out_data_in;
   logic [23:0]          duty_prod [2];
   logic [7:0]           duty [2];
   logic [7:0]           cmd_val [2];
   logic [1:0]           zero;
   logic                 veer_left, veer_right, straight, lamp_lf, lamp_rf;
   logic [3:0]           lamps;

   assign en         = !out_valid_ff || out_ready;
   assign pop_ready  = en;
   assign center_ext = TIME_BITS'(center_pulse);
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;

   // valid chain, whole pipe moves together
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= pop_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   // magnitude select and saturation test
   always_comb begin
      for (int ch = 0; ch < 2; ch++) begin
         mag_in[ch] = s1_pos_ff[ch][TIME_BITS-1] ? s1_neg_ff[ch] : s1_pos_ff[ch];
         sat_in[ch] = (|mag_in[ch][TIME_BITS-1:MB]) || (mag_in[ch][MB-1:0] > rcpd_pkg::MAG_LIMIT);
      end
   end

   // divide by five through reciprocal
   always_comb begin
      for (int ch = 0; ch < 2; ch++) begin
         div_prod[ch] = 17'(s2_mag_ff[ch]) * 17'(rcpd_pkg::DIV5_RECIP);
         q_in[ch] = s2_sat_ff[ch] ? rcpd_pkg::CMD_LIMIT
                                  : div_prod[ch][rcpd_pkg::DIV5_SHIFT +: CB];
      end
   end

   // duty, signed command and lamps
   always_comb begin
      for (int ch = 0; ch < 2; ch++) begin
         duty_prod[ch] = 24'(s3_q_ff[ch]) * 24'(rcpd_pkg::DUTY_RECIP);
         duty[ch]      = duty_prod[ch][rcpd_pkg::DUTY_SHIFT +: 8];
         zero[ch]      = (s3_q_ff[ch] == '0);
         cmd_val[ch]   = s3_sign_ff[ch] ? (8'd0 - {1'b0, s3_q_ff[ch]}) : {1'b0, s3_q_ff[ch]};
      end
      veer_left  = s3_sign_ff[1] && (s3_q_ff[1] > turn_threshold);
      veer_right = !s3_sign_ff[1] && (s3_q_ff[1] > turn_threshold);
      straight   = !veer_left && !veer_right;
      lamp_lf    = (s3_sw_ff[0] && straight) || veer_left;
      lamp_rf    = (s3_sw_ff[0] && straight) || veer_right;
      lamps      = {veer_right, veer_left, lamp_rf, lamp_lf};
      out_data_in = {7'd0,
                     !s3_sw_ff[1],                        // buzzer, low sounds
                     lamps,
                     zero[1],                             // steer_center
                     s3_sign_ff[1] && !zero[1],           // steer_left
                     zero[1] ? 8'd0 : duty[1],            // steer_speed
                     zero[0],                             // drive_brake
                     !s3_sign_ff[0] && !zero[0],          // drive_forward
                     zero[0] ? 8'd0 : duty[0],            // drive_speed
                     cmd_val[1],
                     cmd_val[0]};
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         for (int ch = 0; ch < 2; ch++) begin
            s1_pos_ff[ch] <= pop_data[ch*TIME_BITS +: TIME_BITS] - center_ext;
            s1_neg_ff[ch] <= center_ext - pop_data[ch*TIME_BITS +: TIME_BITS];
            s2_sign_ff[ch] <= s1_pos_ff[ch][TIME_BITS-1];
            s2_sat_ff[ch]  <= sat_in[ch];
            s2_mag_ff[ch]  <= mag_in[ch][MB-1:0];
            s3_sign_ff[ch] <= s2_sign_ff[ch];
            s3_q_ff[ch]    <= q_in[ch];
         end
         s1_sw_ff    <= pop_data[2*TIME_BITS +: 2];
         s2_sw_ff    <= s1_sw_ff;
         s3_sw_ff    <= s2_sw_ff;
         out_data_ff <= out_data_in;
      end
   end

endmodule

### design/rc_pulse_decode_drive_core.sv
// ---------------------------------------------------------------------------
// rc_pulse_decode_drive_core : RC PWM decoder and car drive controller
// Decodes throttle and steering pulse widths each microsecond tick and
// produces motor duty, direction, lamp and buzzer commands.
// ---------------------------------------------------------------------------
// Usage:
//  req_*  one beat per microsecond tick with the four sampled pin levels.
//  rsp_*  one result beat per tick, in order.
//  csr_*  register writes (0 signal timeout, 1 center pulse, 2 turn
//         threshold); other indexes are dropped. Write only while idle.
// Throughput: one tick per cycle sustained while rsp_tready stays high.
// Path: a request beat is written into the queue, then passes four stages of
//  command mapping in the back before it leaves as the result beat.
// Reset: timers and pin history clear, widths return to 1500, registers
//  take their defaults; no result is pending.
// Stall: when rsp_tready is low the back pipe holds, the four-entry queue
//  fills and req_tready drops once it is full; nothing is lost.
// ---------------------------------------------------------------------------
module rc_pulse_decode_drive_core #(
   parameter int TIME_BITS = rcpd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [0] throttle_pin, [1] steering_pin, [2] light_pin, [3] horn_pin
   input  logic [rcpd_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [7:0] throttle_value, [15:8] steering_value, [23:16] drive_speed,
   // [24] drive_forward, [25] drive_brake, [33:26] steer_speed,
   // [34] steer_left, [35] steer_center, [39:36] lamps, [40] buzzer_level
   output logic [rcpd_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rcpd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rcpd_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int ENTRY_BITS = 2 * TIME_BITS + 2;

   logic [rcpd_pkg::TIMEOUT_BITS-1:0]   timeout_ff;
   logic [rcpd_pkg::CENTER_BITS-1:0]    center_ff;
   logic [rcpd_pkg::THRESHOLD_BITS-1:0] threshold_ff;
   logic                                csr_write;

   logic                  push_valid, push_ready;
   logic [ENTRY_BITS-1:0] push_data;
   logic                  pop_valid, pop_ready;
   logic [ENTRY_BITS-1:0] pop_data;

   // configuration registers
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= rcpd_pkg::TIMEOUT_RESET;
         center_ff    <= rcpd_pkg::CENTER_RESET;
         threshold_ff <= rcpd_pkg::THRESHOLD_RESET;
      end else if (csr_write) begin
         case (rcpd_pkg::csr_index_type'(csr_index))
            rcpd_pkg::CSR_SIGNAL_TIMEOUT: begin
               timeout_ff <= csr_data[rcpd_pkg::TIMEOUT_BITS-1:0];
            end
            rcpd_pkg::CSR_CENTER_PULSE: begin
               center_ff <= csr_data[rcpd_pkg::CENTER_BITS-1:0];
            end
            rcpd_pkg::CSR_TURN_THRESHOLD: begin
               threshold_ff <= csr_data[rcpd_pkg::THRESHOLD_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // front: edge timing
   rcpd_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .signal_timeout (timeout_ff),
      .center_pulse   (center_ff),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_pins        (req_tdata[3:0]),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   // queue
   rcpd_queue #(
      .DATA_BITS (ENTRY_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: command mapping
   rcpd_back #(
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .center_pulse   (center_ff),
      .turn_threshold (threshold_ff),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_data       (rsp_tdata)
   );

   // checks
   a_drive_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[24] && rsp_tdata[25]))
      else $error("drive forward and brake both set");

   a_brake_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[25]) |-> (rsp_tdata[23:16] == 8'd0 && rsp_tdata[7:0] == 8'd0))
      else $error("brake with non-zero throttle or duty");

   a_center_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[35]) |-> (rsp_tdata[33:26] == 8'd0 && !rsp_tdata[34]))
      else $error("steer center with duty or left set");

   a_throttle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[7:0]) <= 8'sd100 &&
                      $signed(rsp_tdata[7:0]) >= -8'sd100))
      else $error("throttle command out of range");

endmodule
